FILE: design/wts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_pkg
// Shared widths, stage counts, register map and interface types for the
// world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PIXEL_BITS  = 16;
   localparam int COORD_W     = 32;
   localparam int DIM_W       = 14;

   // |coeff*coord| <= 2^62, three floor-shifted products plus a 32-bit offset
   localparam int DOT_W       = 65 - FRAC_BITS;
   // screen scale and bias factors as signed values
   localparam int K_W         = DIM_W + 1;
   localparam int PROD_W      = DOT_W + K_W;
   localparam int NUM_W       = PROD_W + 1;
   localparam int REM_W       = (NUM_W > DOT_W + PIXEL_BITS) ? NUM_W : DOT_W + PIXEL_BITS;

   // 0.001 in fixed point, rounded down
   localparam int W_THRESH    = (1 << FRAC_BITS) / 1000;

   localparam int DOT_STAGES  = 3;
   localparam int PROJ_STAGES = 4;
   localparam int DIV_STAGES  = PIXEL_BITS;
   localparam int NSTAGES     = DOT_STAGES + PROJ_STAGES + DIV_STAGES;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_IDX_W   = 3;

   localparam logic [REG_IDX_W-1:0] REG_XROW_A   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_XROW_B   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_YROW_A   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_YROW_B   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DEPTH_A  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DEPTH_B  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

   localparam logic [DIM_W-1:0] SCREEN_W_RST = 14'd1920;
   localparam logic [DIM_W-1:0] SCREEN_H_RST = 14'd1080;

   // operand handed from the projection stages to a divider
   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [REM_W-1:0] rem;
      logic [DOT_W-1:0] dvs;
   } div_op_type;

   // divider result: quotient magnitude plus sign and overflow
   typedef struct packed {
      logic                  neg;
      logic                  sat;
      logic [PIXEL_BITS-1:0] quo;
   } div_res_type;

endpackage

FILE: design/world_to_screen_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Perspective projection of Q16.16 world points to saturated screen pixels.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   req_world_x, req_world_y, req_world_z
//   rsp      out  rsp_valid / rsp_ready   rsp_visible, rsp_screen_x, rsp_screen_y
//   csr      in   APB psel/penable/pready csr_paddr, csr_pwdata, csr_prdata
//
// One point per clock sustained while rsp_ready is high. The stages are:
// three dot-product stages, four projection stages, one divider stage
// per pixel bit, and the output register.
// Reset clears all stage valid bits and restores the register defaults.
// Each stage holds only when it and every stage after it are full, so
// bubbles close up and input beats are taken while a result waits.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top
   import wts_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_W-1:0]    req_world_x,
   input  logic signed [COORD_W-1:0]    req_world_y,
   input  logic signed [COORD_W-1:0]    req_world_z,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_visible,
   output logic signed [PIXEL_BITS-1:0] rsp_screen_x,
   output logic signed [PIXEL_BITS-1:0] rsp_screen_y,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int DIV_BASE = DOT_STAGES + PROJ_STAGES;
   localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
   localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

   // ---------------- configuration registers ----------------
   logic [63:0]          coef_ff [6];
   logic [DIM_W-1:0]     scr_w_ff, scr_h_ff;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            coef_ff[i] <= '0;
         end
         scr_w_ff <= SCREEN_W_RST;
         scr_h_ff <= SCREEN_H_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_XROW_A:   coef_ff[0] <= csr_pwdata;
            REG_XROW_B:   coef_ff[1] <= csr_pwdata;
            REG_YROW_A:   coef_ff[2] <= csr_pwdata;
            REG_YROW_B:   coef_ff[3] <= csr_pwdata;
            REG_DEPTH_A:  coef_ff[4] <= csr_pwdata;
            REG_DEPTH_B:  coef_ff[5] <= csr_pwdata;
            REG_SCREEN_W: scr_w_ff   <= csr_pwdata[DIM_W-1:0];
            REG_SCREEN_H: scr_h_ff   <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_XROW_A:   csr_prdata = coef_ff[0];
         REG_XROW_B:   csr_prdata = coef_ff[1];
         REG_YROW_A:   csr_prdata = coef_ff[2];
         REG_YROW_B:   csr_prdata = coef_ff[3];
         REG_DEPTH_A:  csr_prdata = coef_ff[4];
         REG_DEPTH_B:  csr_prdata = coef_ff[5];
         REG_SCREEN_W: csr_prdata = CSR_DATA_W'(scr_w_ff);
         REG_SCREEN_H: csr_prdata = CSR_DATA_W'(scr_h_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   // stage NSTAGES is the output register
   logic [NSTAGES:0] stage_vld_ff;
   logic [NSTAGES:0] stage_vld_in;
   logic [NSTAGES:0] stage_rdy;

   for (genvar i = 0; i <= NSTAGES; i++) begin : g_rdy
      assign stage_rdy[i] = rsp_ready | ~(&stage_vld_ff[NSTAGES:i]);
   end

   assign stage_vld_in = {stage_vld_ff[NSTAGES-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         for (int i = 0; i <= NSTAGES; i++) begin
            if (stage_rdy[i]) begin
               stage_vld_ff[i] <= stage_vld_in[i];
            end
         end
      end
   end

   assign req_ready = stage_rdy[0];
   assign rsp_valid = stage_vld_ff[NSTAGES];

   // ---------------- datapath ----------------
   logic signed [DOT_W-1:0] xd, yd, wd;
   div_op_type              op_x, op_y;
   div_res_type             res_x, res_y;
   logic                    vis_p;
   logic                    vis_ff [DIV_STAGES];

   wts_dot u_dot_x (
      .clock    (clock),
      .stage_en (stage_rdy[DOT_STAGES-1:0]),
      .coefs_a  (coef_ff[0]),
      .coefs_b  (coef_ff[1]),
      .pt_x     (req_world_x),
      .pt_y     (req_world_y),
      .pt_z     (req_world_z),
      .dot      (xd)
   );

   wts_dot u_dot_y (
      .clock    (clock),
      .stage_en (stage_rdy[DOT_STAGES-1:0]),
      .coefs_a  (coef_ff[2]),
      .coefs_b  (coef_ff[3]),
      .pt_x     (req_world_x),
      .pt_y     (req_world_y),
      .pt_z     (req_world_z),
      .dot      (yd)
   );

   wts_dot u_dot_w (
      .clock    (clock),
      .stage_en (stage_rdy[DOT_STAGES-1:0]),
      .coefs_a  (coef_ff[4]),
      .coefs_b  (coef_ff[5]),
      .pt_x     (req_world_x),
      .pt_y     (req_world_y),
      .pt_z     (req_world_z),
      .dot      (wd)
   );

   wts_proj u_proj (
      .clock    (clock),
      .stage_en (stage_rdy[DIV_BASE-1:DOT_STAGES]),
      .xd       (xd),
      .yd       (yd),
      .wd       (wd),
      .screen_w (scr_w_ff),
      .screen_h (scr_h_ff),
      .op_x     (op_x),
      .op_y     (op_y),
      .vis      (vis_p)
   );

   wts_div u_div_x (
      .clock    (clock),
      .stage_en (stage_rdy[NSTAGES-1:DIV_BASE]),
      .op_in    (op_x),
      .res      (res_x)
   );

   wts_div u_div_y (
      .clock    (clock),
      .stage_en (stage_rdy[NSTAGES-1:DIV_BASE]),
      .op_in    (op_y),
      .res      (res_y)
   );

   // visibility rides alongside the divider stages
   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (stage_rdy[DIV_BASE+j]) begin
            vis_ff[j] <= (j == 0) ? vis_p : vis_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   function automatic logic [PIXEL_BITS-1:0] pix_clamp(input div_res_type r);
      logic [PIXEL_BITS-1:0] v;
      if (r.neg) begin
         v = (r.sat || (r.quo > PIX_MIN)) ? PIX_MIN : PIXEL_BITS'(-r.quo);
      end else begin
         v = (r.sat || (r.quo > PIX_MAX)) ? PIX_MAX : r.quo;
      end
      return v;
   endfunction

   logic                  vis_out_ff;
   logic [PIXEL_BITS-1:0] sx_out_ff, sy_out_ff, sx_in, sy_in;

   assign sx_in = vis_ff[DIV_STAGES-1] ? pix_clamp(res_x) : '0;
   assign sy_in = vis_ff[DIV_STAGES-1] ? pix_clamp(res_y) : '0;

   always_ff @(posedge clock) begin
      if (stage_rdy[NSTAGES]) begin
         vis_out_ff <= vis_ff[DIV_STAGES-1];
         sx_out_ff  <= sx_in;
         sy_out_ff  <= sy_in;
      end
   end

   assign rsp_visible  = vis_out_ff;
   assign rsp_screen_x = $signed(sx_out_ff);
   assign rsp_screen_y = $signed(sy_out_ff);

endmodule

FILE: design/wts_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_dot
// One coefficient row dotted with (x, y, z, 1): multiply, floor shift and
// pairwise add, then final add, over three register stages.
// ----------------------------------------------------------------------------
module wts_dot
   import wts_pkg::*;
(
   input  logic                        clock,
   input  logic [DOT_STAGES-1:0]       stage_en,
   input  logic [63:0]                 coefs_a,
   input  logic [63:0]                 coefs_b,
   input  logic signed [COORD_W-1:0]   pt_x,
   input  logic signed [COORD_W-1:0]   pt_y,
   input  logic signed [COORD_W-1:0]   pt_z,
   output logic signed [DOT_W-1:0]     dot
);

   logic signed [63:0]      prod_ff [3];
   logic signed [DOT_W-2:0] sh0, sh1, sh2;
   logic signed [31:0]      offset;
   logic signed [DOT_W-1:0] s01_ff, s01_in;
   logic signed [DOT_W-1:0] s2o_ff, s2o_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;

   // arithmetic shift of the product is the floor shift
   assign sh0    = prod_ff[0][63:FRAC_BITS];
   assign sh1    = prod_ff[1][63:FRAC_BITS];
   assign sh2    = prod_ff[2][63:FRAC_BITS];
   assign offset = coefs_b[63:32];

   assign s01_in = $signed({sh0[DOT_W-2], sh0}) + $signed({sh1[DOT_W-2], sh1});
   assign s2o_in = $signed({sh2[DOT_W-2], sh2})
                 + $signed({{(DOT_W-32){offset[31]}}, offset});
   assign dot_in = s01_ff + s2o_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff[0] <= 64'($signed(coefs_a[31:0]))  * 64'(pt_x);
         prod_ff[1] <= 64'($signed(coefs_a[63:32])) * 64'(pt_y);
         prod_ff[2] <= 64'($signed(coefs_b[31:0]))  * 64'(pt_z);
      end
      if (stage_en[1]) begin
         s01_ff <= s01_in;
         s2o_ff <= s2o_in;
      end
      if (stage_en[2]) begin
         dot_ff <= dot_in;
      end
   end

   assign dot = dot_ff;

endmodule

FILE: design/wts_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_proj
// Builds the two screen numerators and the common divisor 2w, takes sign and
// magnitude, and flags quotients that cannot fit the pixel range.
// ----------------------------------------------------------------------------
module wts_proj
   import wts_pkg::*;
(
   input  logic                     clock,
   input  logic [PROJ_STAGES-1:0]   stage_en,
   input  logic signed [DOT_W-1:0]  xd,
   input  logic signed [DOT_W-1:0]  yd,
   input  logic signed [DOT_W-1:0]  wd,
   input  logic [DIM_W-1:0]         screen_w,
   input  logic [DIM_W-1:0]         screen_h,
   output div_op_type               op_x,
   output div_op_type               op_y,
   output logic                     vis
);

   logic signed [K_W-1:0]    kx_scale, kx_bias, ky_scale, ky_bias;

   // stage A: products
   logic signed [PROD_W-1:0] mx_s_ff, mx_b_ff, my_s_ff, my_b_ff;
   logic [DOT_W-1:0]         dvs_a_ff;
   logic                     vis_a_ff;
   // stage B: numerators
   logic signed [NUM_W-1:0]  nx_ff, ny_ff, nx_in, ny_in;
   logic [DOT_W-1:0]         dvs_b_ff;
   logic                     vis_b_ff;
   // stage C: sign and magnitude
   logic [NUM_W-1:0]         magx_ff, magy_ff;
   logic                     negx_ff, negy_ff;
   logic [DOT_W-1:0]         dvs_c_ff;
   logic                     vis_c_ff;
   // stage D: overflow check
   logic [REM_W:0]           dlim;
   div_op_type               opx_ff, opy_ff, opx_in, opy_in;
   logic                     vis_d_ff;

   // W, 2*(W/2)+1, -H, 2*(H/2)-1
   assign kx_scale = $signed({1'b0, screen_w});
   assign kx_bias  = $signed({1'b0, screen_w[DIM_W-1:1], 1'b1});
   assign ky_scale = -$signed({1'b0, screen_h});
   assign ky_bias  = $signed({1'b0, screen_h[DIM_W-1:1], 1'b0}) - $signed(K_W'(1));

   assign nx_in = $signed(NUM_W'(mx_s_ff)) + $signed(NUM_W'(mx_b_ff));
   assign ny_in = $signed(NUM_W'(my_s_ff)) + $signed(NUM_W'(my_b_ff));

   // quotient >= 2^PIXEL_BITS is out of range on either side
   assign dlim = (REM_W+1)'(dvs_c_ff) << PIXEL_BITS;

   always_comb begin
      opx_in.neg = negx_ff;
      opx_in.sat = ((REM_W+1)'(magx_ff) >= dlim);
      opx_in.rem = REM_W'(magx_ff);
      opx_in.dvs = dvs_c_ff;
      opy_in.neg = negy_ff;
      opy_in.sat = ((REM_W+1)'(magy_ff) >= dlim);
      opy_in.rem = REM_W'(magy_ff);
      opy_in.dvs = dvs_c_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mx_s_ff  <= PROD_W'(xd) * PROD_W'(kx_scale);
         mx_b_ff  <= PROD_W'(wd) * PROD_W'(kx_bias);
         my_s_ff  <= PROD_W'(yd) * PROD_W'(ky_scale);
         my_b_ff  <= PROD_W'(wd) * PROD_W'(ky_bias);
         dvs_a_ff <= {wd[DOT_W-2:0], 1'b0};
         vis_a_ff <= (wd > $signed(DOT_W'(W_THRESH)));
      end
      if (stage_en[1]) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         dvs_b_ff <= dvs_a_ff;
         vis_b_ff <= vis_a_ff;
      end
      if (stage_en[2]) begin
         negx_ff  <= nx_ff[NUM_W-1];
         negy_ff  <= ny_ff[NUM_W-1];
         magx_ff  <= nx_ff[NUM_W-1] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
         magy_ff  <= ny_ff[NUM_W-1] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);
         dvs_c_ff <= dvs_b_ff;
         vis_c_ff <= vis_b_ff;
      end
      if (stage_en[3]) begin
         opx_ff   <= opx_in;
         opy_ff   <= opy_in;
         vis_d_ff <= vis_c_ff;
      end
   end

   assign op_x = opx_ff;
   assign op_y = opy_ff;
   assign vis  = vis_d_ff;

endmodule

FILE: design/wts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_div
// Pipelined restoring divider: one quotient bit per stage, most significant
// first. Operand magnitude is known to be below divisor * 2^PIXEL_BITS
// unless the overflow flag is set.
// ----------------------------------------------------------------------------
module wts_div
   import wts_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  div_op_type            op_in,
   output div_res_type           res
);

   logic [REM_W-1:0]      rem_ff  [DIV_STAGES];
   logic [PIXEL_BITS-1:0] quo_ff  [DIV_STAGES];
   logic [DOT_W-1:0]      dvs_ff  [DIV_STAGES];
   logic                  neg_ff  [DIV_STAGES];
   logic                  sat_ff  [DIV_STAGES];

   logic [REM_W-1:0]      src_rem [DIV_STAGES];
   logic [PIXEL_BITS-1:0] src_quo [DIV_STAGES];
   logic [DOT_W-1:0]      src_dvs [DIV_STAGES];
   logic                  src_neg [DIV_STAGES];
   logic                  src_sat [DIV_STAGES];
   logic [REM_W:0]        diff    [DIV_STAGES];
   logic                  take    [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      localparam int SH = PIXEL_BITS - 1 - k;

      if (k == 0) begin : g_first
         assign src_rem[k] = op_in.rem;
         assign src_quo[k] = '0;
         assign src_dvs[k] = op_in.dvs;
         assign src_neg[k] = op_in.neg;
         assign src_sat[k] = op_in.sat;
      end else begin : g_next
         assign src_rem[k] = rem_ff[k-1];
         assign src_quo[k] = quo_ff[k-1];
         assign src_dvs[k] = dvs_ff[k-1];
         assign src_neg[k] = neg_ff[k-1];
         assign src_sat[k] = sat_ff[k-1];
      end

      assign diff[k] = {1'b0, src_rem[k]} - ((REM_W+1)'(src_dvs[k]) << SH);
      assign take[k] = ~diff[k][REM_W];

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            rem_ff[k] <= take[k] ? diff[k][REM_W-1:0] : src_rem[k];
            quo_ff[k] <= src_quo[k] | (PIXEL_BITS'(take[k]) << SH);
            dvs_ff[k] <= src_dvs[k];
            neg_ff[k] <= src_neg[k];
            sat_ff[k] <= src_sat[k];
         end
      end
   end

   always_comb begin
      res.neg = neg_ff[DIV_STAGES-1];
      res.sat = sat_ff[DIV_STAGES-1];
      res.quo = quo_ff[DIV_STAGES-1];
   end

endmodule

FILE: tb/screen_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_point_checker
// Passive checker for the projection block. It tracks register writes on the
// csr port and predicts the screen point for every accepted req beat. Each
// rsp beat is then compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module screen_point_checker
   import wts_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COORD_W-1:0]    req_world_x,
   input  logic signed [COORD_W-1:0]    req_world_y,
   input  logic signed [COORD_W-1:0]    req_world_z,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_visible,
   input  logic signed [PIXEL_BITS-1:0] rsp_screen_x,
   input  logic signed [PIXEL_BITS-1:0] rsp_screen_y,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic                         csr_pready,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output int                           check_errors,
   output int                           points_in_flight
);

   typedef struct packed {
      logic                         visible;
      logic signed [PIXEL_BITS-1:0] sx;
      logic signed [PIXEL_BITS-1:0] sy;
   } screen_point_type;

   logic [CSR_DATA_W-1:0] coef_regs [6];
   logic [DIM_W-1:0]      view_w;
   logic [DIM_W-1:0]      view_h;
   screen_point_type      pixel_q [$];
   int                    mismatches = 0;

   // row . (p, 1); each product floors on the shift, the offset adds exactly
   function automatic longint row_dot(input logic [CSR_DATA_W-1:0] ta, tb,
                                      input logic signed [COORD_W-1:0] px, py, pz);
      longint acc;
      acc = longint'($signed(tb[63:32]));
      acc += (longint'($signed(ta[31:0])) * longint'(px)) >>> FRAC_BITS;
      acc += (longint'($signed(ta[63:32])) * longint'(py)) >>> FRAC_BITS;
      acc += (longint'($signed(tb[31:0])) * longint'(pz)) >>> FRAC_BITS;
      return acc;
   endfunction

   function automatic logic signed [PIXEL_BITS-1:0] clip_pixel(input logic signed [127:0] q);
      logic signed [127:0] top_val;
      top_val = (128'sd1 <<< (PIXEL_BITS - 1)) - 1;
      if (q > top_val) q = top_val;
      else if (q < -top_val - 1) q = -top_val - 1;
      return q[PIXEL_BITS-1:0];
   endfunction

   function automatic screen_point_type project_point(
         input logic signed [COORD_W-1:0] px, py, pz);
      logic signed [127:0] w, xd, yd, vw, vh, num_x, num_y;
      screen_point_type    r;
      r = '0;
      w = 128'(row_dot(coef_regs[REG_DEPTH_A], coef_regs[REG_DEPTH_B], px, py, pz));
      if (w <= W_THRESH) return r;
      xd = 128'(row_dot(coef_regs[REG_XROW_A], coef_regs[REG_XROW_B], px, py, pz));
      yd = 128'(row_dot(coef_regs[REG_YROW_A], coef_regs[REG_YROW_B], px, py, pz));
      vw = 128'(view_w);
      vh = 128'(view_h);
      // both axes as one exact fraction over 2w, truncated toward zero
      num_x = xd * vw + w * (2 * (vw / 2) + 1);
      num_y = w * (2 * (vh / 2) - 1) - yd * vh;
      r.visible = 1'b1;
      r.sx = clip_pixel(num_x / (2 * w));
      r.sy = clip_pixel(num_y / (2 * w));
      return r;
   endfunction

   always @(posedge clock) begin
      screen_point_type want;
      if (reset) begin
         foreach (coef_regs[i]) coef_regs[i] = '0;
         view_w = SCREEN_W_RST;
         view_h = SCREEN_H_RST;
         pixel_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:3])
               REG_SCREEN_W: view_w = csr_pwdata[DIM_W-1:0];
               REG_SCREEN_H: view_h = csr_pwdata[DIM_W-1:0];
               default: coef_regs[csr_paddr[CSR_ADDR_W-1:3]] = csr_pwdata;
            endcase
         end
         if (req_valid && req_ready)
            pixel_q.push_back(project_point(req_world_x, req_world_y, req_world_z));
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: rsp beat with nothing expected: visible %0b x %0d y %0d",
                        $time, rsp_visible, rsp_screen_x, rsp_screen_y);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_visible !== want.visible) begin
                  $display("%0t: visible mismatch, expected %0b, actual %0b",
                           $time, want.visible, rsp_visible);
                  mismatches++;
               end
               if (rsp_screen_x !== want.sx) begin
                  $display("%0t: screen_x mismatch, expected %0d, actual %0d",
                           $time, want.sx, rsp_screen_x);
                  mismatches++;
               end
               if (rsp_screen_y !== want.sy) begin
                  $display("%0t: screen_y mismatch, expected %0d, actual %0d",
                           $time, want.sy, rsp_screen_y);
                  mismatches++;
               end
            end
         end
      end
      check_errors <= mismatches;
      points_in_flight <= pixel_q.size();
   end

endmodule

FILE: tb/world_to_screen_projection_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_top_test
// Drives world points and register settings into the projection block. A
// directed pass covers reset values, unit rows, the depth threshold,
// saturation and extreme terms and viewports; random phases follow, mostly
// camera-like setups with random content, some with arbitrary registers.
// Checking is done by screen_point_checker.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top_test;
   import wts_pkg::*;

   typedef enum int {SETUP_CAMERA, SETUP_WILD} setup_kind_type;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN   = 32'h8000_0000;
   localparam logic [31:0] EDGE_VALS [5] = '{Q_MIN, Q_MAX, 32'h0, 32'h1, 32'hFFFF_FFFF};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [COORD_W-1:0]    req_world_x = '0;
   logic signed [COORD_W-1:0]    req_world_y = '0;
   logic signed [COORD_W-1:0]    req_world_z = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_visible;
   logic signed [PIXEL_BITS-1:0] rsp_screen_x;
   logic signed [PIXEL_BITS-1:0] rsp_screen_y;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;
   int                           check_errors;
   int                           points_in_flight;

   int gap_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit steady_run = 1'b0;

   world_to_screen_projection_top u_dut (.*);
   screen_point_checker u_checker (.*);

   always #6 clock = ~clock;

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // rsp_ready: random runs of ready and stall bursts
   always @(posedge clock) begin
      if (reset || steady_run) begin
         rsp_ready <= !reset;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
         hold_left <= $urandom_range(0, 7);
      end
   end

   function automatic logic [31:0] jitter(input int span);
      return 32'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [31:0] any_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return EDGE_VALS[$urandom_range(0, 4)];
      if (sel < 5) return $urandom;
      return jitter(1 << 21);
   endfunction

   function automatic logic [63:0] terms(input logic [31:0] lo, hi);
      return {hi, lo};
   endfunction

   // viewport size, sometimes with junk above the 14-bit field
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      logic [CSR_DATA_W-1:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 1)) v = '0;
      case ($urandom_range(0, 9))
         0: v[DIM_W-1:0] = DIM_W'(0);
         1: v[DIM_W-1:0] = DIM_W'(1);
         2: v[DIM_W-1:0] = DIM_W'(8192);
         3: v[DIM_W-1:0] = DIM_W'(16383);
         default: v[DIM_W-1:0] = DIM_W'($urandom_range(2, 8191));
      endcase
      return v;
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 40;
      endcase
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_point(input logic [31:0] px, py, pz);
      if (!steady_run && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_world_x <= px;
      req_world_y <= py;
      req_world_z <= pz;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
   endtask

   task automatic random_setup(output setup_kind_type kind);
      kind = ($urandom_range(0, 4) == 0) ? SETUP_WILD : SETUP_CAMERA;
      if (kind == SETUP_WILD) begin
         csr_write(REG_XROW_A, {$urandom, $urandom});
         csr_write(REG_XROW_B, {$urandom, $urandom});
         csr_write(REG_YROW_A, {$urandom, $urandom});
         csr_write(REG_YROW_B, {$urandom, $urandom});
         csr_write(REG_DEPTH_A, {$urandom, $urandom});
         csr_write(REG_DEPTH_B, {$urandom, $urandom});
      end else begin
         // near-unit diagonal rows, depth dominated by z
         csr_write(REG_XROW_A, terms(Q_ONE + jitter(32'h8000), jitter(32'h2000)));
         csr_write(REG_XROW_B, terms(jitter(32'h2000), jitter(32'h4_0000)));
         csr_write(REG_YROW_A, terms(jitter(32'h2000), Q_ONE + jitter(32'h8000)));
         csr_write(REG_YROW_B, terms(jitter(32'h2000), jitter(32'h4_0000)));
         csr_write(REG_DEPTH_A, terms(jitter(32'h1000), jitter(32'h1000)));
         csr_write(REG_DEPTH_B, terms(Q_ONE + jitter(32'h4000), jitter(32'h2_0000)));
      end
      csr_write(REG_SCREEN_W, pick_dim());
      csr_write(REG_SCREEN_H, pick_dim());
   endtask

   initial begin
      setup_kind_type kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct <= 20;

      // rows still at reset: nothing is in front of the camera
      send_point(32'h0, 32'h0, 32'h0);
      send_point(Q_MAX, Q_MAX, Q_MAX);
      send_point(Q_MIN, Q_MIN, Q_MIN);
      wait_drained();

      // unit rows, w = z, viewport left at its reset size
      csr_write(REG_XROW_A, terms(Q_ONE, 32'h0));
      csr_write(REG_XROW_B, '0);
      csr_write(REG_YROW_A, terms(32'h0, Q_ONE));
      csr_write(REG_YROW_B, '0);
      csr_write(REG_DEPTH_A, '0);
      csr_write(REG_DEPTH_B, terms(Q_ONE, 32'h0));
      send_point(32'h0, 32'h0, Q_ONE);
      send_point(Q_ONE, Q_ONE, Q_ONE);
      send_point(32'hFFFF_0000, 32'hFFFF_0000, Q_ONE);
      send_point(32'h0000_8000, 32'hFFFF_8000, Q_ONE);
      send_point(32'h0, 32'h0, W_THRESH);
      send_point(Q_ONE, 32'hFFFF_0000, W_THRESH + 1);
      send_point(Q_MAX, Q_MIN, W_THRESH + 1);
      send_point(Q_MIN, Q_MAX, Q_ONE);
      send_point(32'h0, 32'h0, Q_MIN);
      send_point(Q_MAX, Q_MAX, Q_MAX);
      wait_drained();

      // extreme terms everywhere, zero width, widest height
      csr_write(REG_XROW_A, terms(Q_MIN, Q_MAX));
      csr_write(REG_XROW_B, terms(Q_MAX, Q_MIN));
      csr_write(REG_YROW_A, terms(Q_MAX, Q_MIN));
      csr_write(REG_YROW_B, terms(Q_MIN, Q_MAX));
      csr_write(REG_DEPTH_A, terms(Q_MAX, Q_MIN));
      csr_write(REG_DEPTH_B, terms(Q_MIN, Q_MAX));
      csr_write(REG_SCREEN_W, 64'hFFFF_FFFF_FFFF_C000);
      csr_write(REG_SCREEN_H, 64'h3FFF);
      send_point(Q_MIN, Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MAX, Q_MAX);
      send_point(Q_MIN, Q_MAX, Q_MIN);
      send_point(32'h1, 32'hFFFF_FFFF, 32'h0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(Q_MAX, Q_MIN, Q_MAX);
      wait_drained();

      // depth pinned just above threshold by the offset, one-pixel viewport
      csr_write(REG_DEPTH_A, '0);
      csr_write(REG_DEPTH_B, terms(32'h0, W_THRESH + 1));
      csr_write(REG_SCREEN_W, 64'h1);
      csr_write(REG_SCREEN_H, 64'h1);
      repeat (3) send_point(any_coord(), any_coord(), any_coord());
      wait_drained();

      for (int ph = 0; ph < 9; ph++) begin
         random_setup(kind);
         gap_pct = pick_idle();
         stall_pct <= pick_idle();
         if (ph == 8) steady_run <= 1'b1;
         repeat (ph == 8 ? 160 : 130) begin
            if (kind == SETUP_CAMERA && $urandom_range(0, 9) != 0)
               send_point(jitter(32'h20_0000), jitter(32'h20_0000),
                          $urandom_range(0, 32'h40_0000));
            else
               send_point(any_coord(), any_coord(), any_coord());
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (check_errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: world_to_screen_projection_top.f
design/wts_pkg.sv
design/wts_dot.sv
design/wts_proj.sv
design/wts_div.sv
design/world_to_screen_projection_top.sv
tb/screen_point_checker.sv
tb/world_to_screen_projection_top_test.sv
